// ----- src/base64_stream_encoder_assert.svh -----
// Assertion macros shared by the base64 encoder RTL
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define B64E_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define B64E_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/b64e_pkg.sv -----
// Types, constants and the alphabet function of the base64 encoder
`default_nettype none

package b64e_pkg;

	// Depth of the group queue between front and back (2 or more)
	localparam int unsigned QUEUE_DEPTH = 2;

	// Character codes
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_PLUS    = 8'h2B;
	localparam logic [7:0] CHAR_SLASH   = 8'h2F;
	localparam logic [7:0] CHAR_PAD     = 8'h3D;

	// Pad counts for a closed group
	localparam logic [1:0] PAD_NONE = 2'd0;
	localparam logic [1:0] PAD_ONE  = 2'd1;
	localparam logic [1:0] PAD_TWO  = 2'd2;

	// One 24-bit group as handed from front to back
	typedef struct packed {
		logic [23:0] triple;   // first byte in the high bits
		logic [1:0]  pad_n;    // trailing '=' characters, 0 to 2
		logic        msg_end;  // group closes the message
	} grp_t;

	// Map a sextet onto the standard alphabet
	function automatic logic [7:0] b64_char(input logic [5:0] s);
		logic [7:0] c;
		if (s < 6'd26) begin
			c = CHAR_UPPER_A + {2'b00, s};
		end else if (s < 6'd52) begin
			c = CHAR_LOWER_A + {2'b00, s} - 8'd26;
		end else if (s < 6'd62) begin
			c = CHAR_ZERO + {2'b00, s} - 8'd52;
		end else if (s == 6'd62) begin
			c = CHAR_PLUS;
		end else begin
			c = CHAR_SLASH;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- src/b64e_front.sv -----
// Front end: collects bytes into 24-bit groups and queues closed groups
`default_nettype none

module b64e_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	input  wire logic [7:0]      s_tdata,   // [7:0] data_byte
	input  wire logic            s_tlast,   // final_byte
	input  wire logic            q_full,
	output logic                 q_wr,
	output b64e_pkg::grp_t       q_wdata
);

	logic [15:0] pend_q;
	logic [1:0]  cnt_q;
	logic        beat;
	logic        close_grp;

	// Take a byte whenever the queue can hold a group
	assign s_tready  = !q_full;
	assign beat      = s_tvalid && s_tready;
	assign close_grp = cnt_q[1] || s_tlast;
	assign q_wr      = beat && close_grp;

	// Form the group from held bytes and the new one
	always_comb begin
		q_wdata.msg_end = s_tlast;
		if (cnt_q[1]) begin
			q_wdata.triple = {pend_q, s_tdata};
			q_wdata.pad_n  = b64e_pkg::PAD_NONE;
		end else if (cnt_q[0]) begin
			q_wdata.triple = {pend_q[7:0], s_tdata, 8'h00};
			q_wdata.pad_n  = b64e_pkg::PAD_ONE;
		end else begin
			q_wdata.triple = {s_tdata, 16'h0000};
			q_wdata.pad_n  = b64e_pkg::PAD_TWO;
		end
	end

	// Held bytes, earlier byte above the later one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			cnt_q  <= '0;
		end else if (beat) begin
			if (close_grp) begin
				pend_q <= '0;
				cnt_q  <= '0;
			end else begin
				pend_q <= {pend_q[7:0], s_tdata};
				cnt_q  <= cnt_q + 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/b64e_queue.sv -----
// Short group queue between the front and back ends
`default_nettype none
`include "base64_stream_encoder_assert.svh"

module b64e_queue #(
	parameter int unsigned DEPTH = b64e_pkg::QUEUE_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr,
	input  wire b64e_pkg::grp_t  wdata,
	output logic                 full,
	input  wire logic            rd,
	output b64e_pkg::grp_t       rdata,
	output logic                 not_empty
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	b64e_pkg::grp_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full      = (count_q == CNT_FULL);
	assign not_empty = (count_q != '0);
	assign do_wr     = wr && !full;
	assign do_rd     = rd && not_empty;
	assign rdata     = mem_q[rptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PTR_LAST) ? '0 : rptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	`B64E_ASSERT_NOW(a_cnt_range, 1'b1, count_q <= CNT_FULL, "queue count beyond depth")
	`B64E_ASSERT_NEXT(a_cnt_up, do_wr && !do_rd, count_q == $past(count_q) + CNT_W'(1), "queue count missed a write")

endmodule

`default_nettype wire

// ----- src/b64e_back.sv -----
// Back end: spells each group out as four characters, one per cycle while the output is not held back
`default_nettype none
`include "base64_stream_encoder_assert.svh"

module b64e_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_valid,
	input  wire b64e_pkg::grp_t  q_rdata,
	output logic                 q_rd,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output logic [7:0]           m_tdata,   // [7:0] out_char
	output logic                 m_tuser,   // group_last
	output logic                 m_tlast    // message_last
);

	b64e_pkg::grp_t grp_q;
	logic           busy_q;
	logic [1:0]     idx_q;
	logic           out_valid_q;
	logic [7:0]     out_char_q;
	logic           group_last_q;
	logic           msg_last_q;
	logic           adv;
	logic           last_char;
	logic [5:0]     sextet;
	logic           is_pad;
	logic [7:0]     char_nxt;

	// A character moves into the output register when it is free or drains
	assign adv       = busy_q && (!out_valid_q || m_tready);
	assign last_char = (idx_q == 2'd3);
	assign q_rd      = q_valid && (!busy_q || (adv && last_char));

	// Sextet select, most significant first
	always_comb begin
		case (idx_q)
			2'd0:    sextet = grp_q.triple[23:18];
			2'd1:    sextet = grp_q.triple[17:12];
			2'd2:    sextet = grp_q.triple[11:6];
			default: sextet = grp_q.triple[5:0];
		endcase
	end

	assign is_pad   = (idx_q > (2'd3 - grp_q.pad_n));
	assign char_nxt = is_pad ? b64e_pkg::CHAR_PAD : b64e_pkg::b64_char(sextet);

	// Current group and character index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (q_rd) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (adv) begin
			if (last_char) begin
				busy_q <= 1'b0;
			end
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			grp_q <= q_rdata;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_char_q   <= char_nxt;
			group_last_q <= last_char;
			msg_last_q   <= last_char && grp_q.msg_end;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_char_q;
	assign m_tuser  = group_last_q;
	assign m_tlast  = msg_last_q;

	`B64E_ASSERT_NOW(a_pop_gap, q_rd && busy_q, adv && last_char, "group taken while one is still open")
	`B64E_ASSERT_NEXT(a_pop_start, q_rd, busy_q && (idx_q == 2'd0), "taken group did not start at its first character")
	`B64E_ASSERT_NOW(a_msg_in_grp, out_valid_q && msg_last_q, group_last_q, "message end off a group boundary")

endmodule

`default_nettype wire

// ----- src/base64_stream_encoder.sv -----
// Path: a byte that closes a group is written to the group queue, then taken into the back end's group
// register, and its first character shows from the output register. Throughput: one character per cycle
// on the output while m_tready is high, four per group; the output register and the group queue set the pace.
// Input takes one byte per cycle while the group queue has room.
// Reset (arst_n low, asynchronous) clears held bytes, the queue and the output valid.
// Top level of the base64 stream encoder
`default_nettype none

module base64_stream_encoder #(
	parameter int unsigned QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic        s_tlast,   // final_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // [7:0] out_char
	output logic             m_tuser,   // group_last
	output logic             m_tlast    // message_last
);

	logic           q_wr;
	logic           q_full;
	logic           q_rd;
	logic           q_valid;
	b64e_pkg::grp_t q_wdata;
	b64e_pkg::grp_t q_rdata;

	// Byte collection
	b64e_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.q_wr     (q_wr),
		.q_wdata  (q_wdata)
	);

	// Group queue
	b64e_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (q_wr),
		.wdata     (q_wdata),
		.full      (q_full),
		.rd        (q_rd),
		.rdata     (q_rdata),
		.not_empty (q_valid)
	);

	// Character output
	b64e_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_rdata  (q_rdata),
		.q_rd     (q_rd),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

// ----- tb/sv/base64_stream_encoder_test.sv -----
// Self-checking testbench for the base64 stream encoder: directed table, then random messages
`default_nettype none

module base64_stream_encoder_test;

	// One encoded character as it leaves the block
	typedef struct packed {
		logic [7:0] code;
		logic       grp_end;
		logic       msg_end;
	} enc_char_t;

	// One row of the directed table; text is zero where the predictor decides
	typedef struct packed {
		logic [7:0]  data;
		logic        is_last;
		logic [31:0] text;
	} stim_row_t;

	localparam int unsigned RANDOM_BEATS = 196;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned REPORT_MAX   = 10;

	// Standard alphabet, index 0 in the top byte
	localparam logic [8*64-1:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tlast;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic       m_tuser;
	logic       m_tlast;

	base64_stream_encoder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Predictor state: bytes held towards the next group
	logic [15:0] held_bytes;
	logic [1:0]  held_cnt;

	enc_char_t   chars_due[$];
	stim_row_t   dir_rows[$];
	logic [31:0] cur_text;
	bit          tx_gap_en;
	bit          rx_stall_en;
	int unsigned mismatches;
	int unsigned beats_in;
	int unsigned chars_out;
	int unsigned msgs_sent;
	int unsigned rx_hold;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	initial begin
		#3000000;
		$display("base64_stream_encoder verification failed");
		$finish;
	end

	// Idle length: mostly none or short, now and then long
	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] sextet_ascii(input logic [5:0] s);
		return ALPHABET[8*(63 - s) +: 8];
	endfunction

	// Encode one accepted byte; a closed group queues four characters
	task automatic encode_byte(input logic [7:0] b, input logic is_last, input logic [31:0] text);
		logic [23:0] triple;
		int unsigned real_n;
		enc_char_t   c;
		if (held_cnt >= 2'd2) begin
			triple = {held_bytes, b};
			real_n = 4;
		end else if (is_last) begin
			if (held_cnt == 2'd0) begin
				triple = {b, 16'h0000};
				real_n = 2;
			end else begin
				triple = {held_bytes[7:0], b, 8'h00};
				real_n = 3;
			end
		end else begin
			held_bytes = {held_bytes[7:0], b};
			held_cnt   = held_cnt + 2'd1;
			return;
		end
		for (int k = 0; k < 4; k++) begin
			if (text != 32'd0) begin
				c.code = text[31 - 8*k -: 8];
			end else if (k < real_n) begin
				c.code = sextet_ascii(triple[23 - 6*k -: 6]);
			end else begin
				c.code = b64e_pkg::CHAR_PAD;
			end
			c.grp_end = (k == 3);
			c.msg_end = (k == 3) && is_last;
			chars_due.push_back(c);
		end
		held_bytes = 16'h0000;
		held_cnt   = 2'd0;
	endtask

	// Beat monitor: predict on input beats, check output beats
	always @(posedge clk) begin
		enc_char_t got;
		enc_char_t want;
		if (arst_n && s_tvalid && s_tready) begin
			encode_byte(s_tdata, s_tlast, cur_text);
			beats_in++;
		end
		if (arst_n && m_tvalid && m_tready) begin
			got = '{code: m_tdata, grp_end: m_tuser, msg_end: m_tlast};
			chars_out++;
			if (chars_due.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected char %h user %b last %b", m_tdata, m_tuser, m_tlast);
			end else begin
				want = chars_due.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("char %0d: want %h/%b/%b got %h/%b/%b", chars_out,
							want.code, want.grp_end, want.msg_end,
							got.code, got.grp_end, got.msg_end);
				end
			end
		end
	end

	// Output back-pressure
	initial begin
		m_tready = 1'b0;
		rx_hold  = 0;
		forever begin
			@(negedge clk);
			if (!rx_stall_en) begin
				m_tready = 1'b1;
			end else if (rx_hold > 0) begin
				m_tready = 1'b0;
				rx_hold--;
			end else begin
				m_tready = 1'b1;
				if ($urandom_range(0, 3) == 0)
					rx_hold = gap_len();
			end
		end
	end

	// Drive one byte beat; called and returns at a falling edge with valid left high
	task automatic send_beat(input logic [7:0] b, input logic is_last, input logic [31:0] text);
		int unsigned gap;
		gap = tx_gap_en ? gap_len() : 0;
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = b;
		s_tlast  = is_last;
		cur_text = text;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		if (is_last)
			msgs_sent++;
	endtask

	task automatic add_row(input logic [7:0] b, input logic is_last, input logic [31:0] text);
		dir_rows.push_back('{data: b, is_last: is_last, text: text});
	endtask

	// Stimulus
	initial begin
		int unsigned len;
		int unsigned r;
		int unsigned sent;
		logic [7:0]  b;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = 8'h00;
		s_tlast     = 1'b0;
		cur_text    = 32'd0;
		tx_gap_en   = 1'b0;
		rx_stall_en = 1'b0;
		held_bytes  = 16'h0000;
		held_cnt    = 2'd0;
		mismatches  = 0;
		beats_in    = 0;
		chars_out   = 0;
		msgs_sent   = 0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table: one-byte tails, two-byte tails, full groups, both extremes
		add_row(8'h00, 1'b1, "AA==");
		add_row(8'hFF, 1'b1, "/w==");
		add_row(8'h00, 1'b0, 32'd0);
		add_row(8'h00, 1'b0, 32'd0);
		add_row(8'h00, 1'b1, "AAAA");
		add_row(8'hFF, 1'b0, 32'd0);
		add_row(8'hFF, 1'b0, 32'd0);
		add_row(8'hFF, 1'b0, "////");
		add_row(8'hFF, 1'b0, 32'd0);
		add_row(8'hFF, 1'b1, "//8=");
		add_row(8'h00, 1'b0, 32'd0);
		add_row(8'h00, 1'b1, "AAA=");
		add_row(8'h4D, 1'b0, 32'd0);
		add_row(8'h61, 1'b0, 32'd0);
		add_row(8'h6E, 1'b0, "TWFu");
		add_row(8'h4D, 1'b0, 32'd0);
		add_row(8'h61, 1'b1, "TWE=");
		add_row(8'h4D, 1'b1, "TQ==");
		add_row(8'hFB, 1'b0, 32'd0);
		add_row(8'hEF, 1'b0, 32'd0);
		add_row(8'hBE, 1'b1, "++++");
		add_row(8'h01, 1'b1, 32'd0);
		add_row(8'h80, 1'b0, 32'd0);
		add_row(8'h7F, 1'b1, 32'd0);
		foreach (dir_rows[i])
			send_beat(dir_rows[i].data, dir_rows[i].is_last, dir_rows[i].text);

		// Random messages, pressure pattern changing every few messages
		sent = 0;
		while (sent < RANDOM_BEATS) begin
			case ((msgs_sent / 4) % 4)
				0: begin tx_gap_en = 1'b1; rx_stall_en = 1'b1; end
				1: begin tx_gap_en = 1'b0; rx_stall_en = 1'b0; end
				2: begin tx_gap_en = 1'b0; rx_stall_en = 1'b1; end
				default: begin tx_gap_en = 1'b1; rx_stall_en = 1'b0; end
			endcase
			len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(7, 20);
			for (int j = 0; j < len; j++) begin
				r = $urandom_range(0, 9);
				b = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
				send_beat(b, (j == len - 1), 32'd0);
			end
			sent += len;
		end
		s_tvalid = 1'b0;

		// Drain
		while (chars_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d byte beats in %0d messages, %0d characters checked",
			beats_in, msgs_sent, chars_out);
		$display("mismatches: %0d", mismatches);
		if (mismatches == 0) begin
			$display("base64_stream_encoder verification clean");
		end else begin
			$display("base64_stream_encoder verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
